// File: rtl/jse_pkg.sv
// Package with the shared types, character constants and helpers of the string escaper.
`default_nettype none

package jse_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_SHORT,
        CLS_UNI,
        CLS_QUOTES
    } cls_t;

    // One queued request: how to expand it and which quotes surround it.
    typedef struct packed {
        cls_t       cls;
        logic [7:0] val;
        logic       lead_q;
        logic       tail_q;
    } desc_t;

    function automatic logic [2:0] body_len(input cls_t cls);
        logic [2:0] len;
        begin
            case (cls)
                CLS_PLAIN:  len = 3'd1;
                CLS_SHORT:  len = 3'd2;
                CLS_UNI:    len = 3'd6;
                CLS_QUOTES: len = 3'd0;
                default:    len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        begin
            if (nib < 4'd10)
            begin
                d = {4'h0, nib} + 8'h30;
            end
            else
            begin
                d = {4'h0, nib} + 8'h37;
            end
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/javascript_string_escaper_unit.sv
// Top level of the JavaScript string escaper: front end, request queue and back end.
// The back end emits one output byte per cycle while out_stall is low. A request yields
// one byte for a printable byte that needs no escape, two for a backslash escape, six
// for a \u00XX escape, plus one for each surrounding quote when quoting is on, and two
// for an empty string with quoting on. Plain bytes without quotes therefore stream at
// one per cycle. An empty string with quoting off emits nothing and is
// not queued. The input is stalled only once the request queue (QUEUE_DEPTH entries) is
// full. include_quotes is written through cfg_write/cfg_data and should only be changed
// while the block is idle.
`default_nettype none

module javascript_string_escaper_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] ch,
    input  wire logic       first_char,
    input  wire logic       last_char,
    input  wire logic       empty_string,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run
);

    jse_pkg::desc_t push_desc;
    jse_pkg::desc_t head_desc;
    logic           push;
    logic           pop;
    logic           head_valid;
    logic           q_full;

    jse_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .ch           (ch),
        .first_char   (first_char),
        .last_char    (last_char),
        .empty_string (empty_string),
        .q_full       (q_full),
        .push_desc    (push_desc),
        .push         (push)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .head_desc  (head_desc),
        .head_valid (head_valid),
        .full       (q_full)
    );

    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_desc   (head_desc),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    assign in_stall = q_full;

endmodule

`default_nettype wire

// File: rtl/jse_front.sv
// Front end: holds the quoting register, accepts requests and classifies each byte.
`default_nettype none

module jse_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic          cfg_data,
    input  wire logic          in_valid,
    input  wire logic [7:0]    ch,
    input  wire logic          first_char,
    input  wire logic          last_char,
    input  wire logic          empty_string,
    input  wire logic          q_full,
    output jse_pkg::desc_t     push_desc,
    output logic               push
);

    logic       quotes_reg;
    logic       accept;
    logic [7:0] short_code;
    logic       is_short;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quotes_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            quotes_reg <= cfg_data;
        end
    end

    always_comb
    begin
        is_short   = 1'b1;
        short_code = ch;
        case (ch)
            jse_pkg::CH_QUOTE:  short_code = jse_pkg::CH_QUOTE;
            jse_pkg::CH_BSLASH: short_code = jse_pkg::CH_BSLASH;
            jse_pkg::CH_BS:     short_code = jse_pkg::CH_B;
            jse_pkg::CH_FF:     short_code = jse_pkg::CH_F;
            jse_pkg::CH_LF:     short_code = jse_pkg::CH_N;
            jse_pkg::CH_CR:     short_code = jse_pkg::CH_R;
            jse_pkg::CH_TAB:    short_code = jse_pkg::CH_T;
            default:            is_short = 1'b0;
        endcase
    end

    always_comb
    begin
        accept = in_valid && !q_full;
        // An empty string with quoting off produces nothing, so it is not queued.
        push   = accept && !(empty_string && !quotes_reg);

        push_desc.val    = ch;
        push_desc.lead_q = quotes_reg && first_char;
        push_desc.tail_q = quotes_reg && last_char;
        if (empty_string)
        begin
            push_desc.cls    = jse_pkg::CLS_QUOTES;
            push_desc.lead_q = 1'b1;
            push_desc.tail_q = 1'b1;
        end
        else if (is_short)
        begin
            push_desc.cls = jse_pkg::CLS_SHORT;
            push_desc.val = short_code;
        end
        else if (!(ch inside {[jse_pkg::PRINT_LO:jse_pkg::PRINT_HI]}))
        begin
            push_desc.cls = jse_pkg::CLS_UNI;
        end
        else
        begin
            push_desc.cls = jse_pkg::CLS_PLAIN;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jse_queue.sv
// Short register queue of classified requests between the front and back ends.
`default_nettype none

module jse_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire jse_pkg::desc_t push_desc,
    input  wire logic           pop,
    output jse_pkg::desc_t      head_desc,
    output logic                head_valid,
    output logic                full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_pkg::desc_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    always_comb
    begin
        head_valid = (count_reg != '0);
        full       = (count_reg == CNT_W'(DEPTH));
        head_desc  = mem_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jse_back.sv
// Back end: expands the queued request at the head into its run of output bytes.
`default_nettype none

module jse_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire jse_pkg::desc_t head_desc,
    input  wire logic           head_valid,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                last_of_run
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [2:0] len;
    logic [3:0] total;
    logic [2:0] b;
    logic [7:0] body_byte;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       advance;

    always_comb
    begin
        len   = jse_pkg::body_len(head_desc.cls);
        total = {3'b000, head_desc.lead_q} + {1'b0, len} + {3'b000, head_desc.tail_q};
        b     = idx_reg - {2'b00, head_desc.lead_q};

        case (head_desc.cls)
            jse_pkg::CLS_PLAIN:
            begin
                body_byte = head_desc.val;
            end
            jse_pkg::CLS_SHORT:
            begin
                body_byte = (b == 3'd0) ? jse_pkg::CH_BSLASH : head_desc.val;
            end
            jse_pkg::CLS_UNI:
            begin
                case (b)
                    3'd0:    body_byte = jse_pkg::CH_BSLASH;
                    3'd1:    body_byte = jse_pkg::CH_U;
                    3'd2:    body_byte = jse_pkg::CH_ZERO;
                    3'd3:    body_byte = jse_pkg::CH_ZERO;
                    3'd4:    body_byte = jse_pkg::hex_digit(head_desc.val[7:4]);
                    3'd5:    body_byte = jse_pkg::hex_digit(head_desc.val[3:0]);
                    default: body_byte = jse_pkg::CH_ZERO;
                endcase
            end
            default:
            begin
                body_byte = jse_pkg::CH_QUOTE;
            end
        endcase

        // Opening quote, then the body, then the closing quote.
        if (head_desc.lead_q && idx_reg == 3'd0)
        begin
            cur_byte = jse_pkg::CH_QUOTE;
        end
        else if (b < len)
        begin
            cur_byte = body_byte;
        end
        else
        begin
            cur_byte = jse_pkg::CH_QUOTE;
        end
        cur_last = ({1'b0, idx_reg} == total - 4'd1);

        advance    = head_valid && (!valid_reg || !out_stall);
        pop        = advance && cur_last;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            idx_next   = cur_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= cur_byte;
            last_reg <= cur_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// File: rtl/jse_checker.sv
// Port-level checker for the string escaper, bound to the top level.
`default_nettype none

module jse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run
);

    // While reset is held nothing is offered and no request is refused.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && !in_stall))
        else $error("output valid or input stall during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(last_of_run)))
        else $error("stalled output request changed");

    // Every emitted byte is printable: control and high bytes are always escaped.
    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte >= 8'h20 && out_byte <= 8'h7E))
        else $error("unescaped byte on output");

    // The queue can only fill up while the output side holds a pending byte.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with nothing pending at output");

endmodule

bind javascript_string_escaper_unit jse_checker u_jse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);

`default_nettype wire

// File: bench/tb_javascript_string_escaper_unit.sv
// Self-checking testbench for the JavaScript string escaper: directed, random and hold-off tests.
`timescale 1ns / 1ps

module tb_javascript_string_escaper_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } esc_byte_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] ch;
    logic       first_char;
    logic       last_char;
    logic       empty_string;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;

    // Our own copy of the quoting register, updated when the block's copy is written.
    logic        quotes_on = 1'b0;
    esc_byte_t   expected_bytes[$];
    esc_byte_t   got;
    bit          in_take = 1'b0;
    bit          out_take = 1'b0;
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    bit          hold_req = 1'b0;
    int          sent_items = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;

    javascript_string_escaper_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .first_char   (first_char),
        .last_char    (last_char),
        .empty_string (empty_string),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? {4'h3, nib} : 8'h40 + {4'h0, nib - 4'd9};
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        expected_bytes.push_back('{b, 1'b0});
    endfunction

    // Appends the escaped text of one request to the queue of expected bytes.
    function automatic void predict_escape(input logic [7:0] c, input logic f, input logic l,
                                           input logic e);
        int         start;
        logic [7:0] code;
        start = expected_bytes.size();
        code = 8'h00;
        if (e)
        begin
            if (quotes_on)
            begin
                push_byte(jse_pkg::CH_QUOTE);
                push_byte(jse_pkg::CH_QUOTE);
            end
        end
        else
        begin
            if (quotes_on && f)
                push_byte(jse_pkg::CH_QUOTE);
            case (c)
                jse_pkg::CH_QUOTE:  code = jse_pkg::CH_QUOTE;
                jse_pkg::CH_BSLASH: code = jse_pkg::CH_BSLASH;
                jse_pkg::CH_BS:     code = jse_pkg::CH_B;
                jse_pkg::CH_FF:     code = jse_pkg::CH_F;
                jse_pkg::CH_LF:     code = jse_pkg::CH_N;
                jse_pkg::CH_CR:     code = jse_pkg::CH_R;
                jse_pkg::CH_TAB:    code = jse_pkg::CH_T;
                default:            code = 8'h00;
            endcase
            if (code != 8'h00)
            begin
                push_byte(jse_pkg::CH_BSLASH);
                push_byte(code);
            end
            else if (c < jse_pkg::PRINT_LO || c > jse_pkg::PRINT_HI)
            begin
                push_byte(jse_pkg::CH_BSLASH);
                push_byte(jse_pkg::CH_U);
                push_byte(jse_pkg::CH_ZERO);
                push_byte(jse_pkg::CH_ZERO);
                push_byte(hex_ascii(c[7:4]));
                push_byte(hex_ascii(c[3:0]));
            end
            else
            begin
                push_byte(c);
            end
            if (quotes_on && l)
                push_byte(jse_pkg::CH_QUOTE);
        end
        if (expected_bytes.size() > start)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(2, 1);
        else if (r < 95)
            return $urandom_range(8, 3);
        return $urandom_range(40, 15);
    endfunction

    function automatic int tx_gap();
        if (!tx_idle_on || $urandom_range(99) < 55)
            return 0;
        return idle_len();
    endfunction

    // Mix of plain text, short escapes and bytes that need a \u escape.
    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 35)
            c = 8'($urandom_range(8'h7E, 8'h20));
        else if (r < 55)
        begin
            case ($urandom_range(6))
                0:       c = jse_pkg::CH_QUOTE;
                1:       c = jse_pkg::CH_BSLASH;
                2:       c = jse_pkg::CH_BS;
                3:       c = jse_pkg::CH_FF;
                4:       c = jse_pkg::CH_LF;
                5:       c = jse_pkg::CH_CR;
                default: c = jse_pkg::CH_TAB;
            endcase
        end
        else
            c = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken or after the gap.
    task automatic send_char(input logic [7:0] c, input logic f, input logic l, input logic e);
        bit took;
        int gap;
        ch <= c;
        first_char <= f;
        last_char <= l;
        empty_string <= e;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            if (took)
            begin
                predict_escape(c, f, l, e);
                sent_items++;
            end
            @(posedge clk);
        end
        while (!took);
        gap = tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A request that yields no output is never queued in the block, so it is gone when the queue runs dry.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_quotes(input logic v);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        quotes_on = v;
    endtask

    task automatic test_plain_bytes();
        set_quotes(1'b0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_char(jse_pkg::PRINT_LO, 1'b1, 1'b0, 1'b0);
        send_char(jse_pkg::PRINT_HI, 1'b0, 1'b0, 1'b0);
        send_char(8'h41, 1'b0, 1'b0, 1'b0);
        send_char(8'h30, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_short_escapes();
        send_char(jse_pkg::CH_QUOTE, 1'b1, 1'b0, 1'b0);
        send_char(jse_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0);
        send_char(jse_pkg::CH_BS, 1'b0, 1'b0, 1'b0);
        send_char(jse_pkg::CH_FF, 1'b0, 1'b0, 1'b0);
        send_char(jse_pkg::CH_LF, 1'b0, 1'b0, 1'b0);
        send_char(jse_pkg::CH_CR, 1'b0, 1'b0, 1'b0);
        send_char(jse_pkg::CH_TAB, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_unicode_escapes();
        send_char(8'h00, 1'b1, 1'b0, 1'b0);
        send_char(8'h1F, 1'b0, 1'b0, 1'b0);
        send_char(8'h7F, 1'b0, 1'b0, 1'b0);
        send_char(8'h80, 1'b0, 1'b0, 1'b0);
        send_char(8'hFF, 1'b0, 1'b0, 1'b0);
        send_char(8'h0B, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_quoting();
        set_quotes(1'b1);
        send_char(8'h41, 1'b1, 1'b0, 1'b0);
        send_char(jse_pkg::CH_QUOTE, 1'b0, 1'b1, 1'b0);
        // One byte marked first and last with the longest escape gives the longest run.
        send_char(8'hFF, 1'b1, 1'b1, 1'b0);
        // The byte and markers of an empty string must be ignored.
        send_char(8'hFF, 1'b1, 1'b1, 1'b1);
        send_char(8'h7A, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_empty_without_quotes();
        set_quotes(1'b0);
        send_char(8'h00, 1'b0, 1'b0, 1'b1);
        send_char(8'hA5, 1'b1, 1'b1, 1'b1);
        send_char(8'h61, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_random_strings(input logic quoting, input int items, input bit tx_idle,
                                       input bit rx_idle);
        int target;
        int len;
        int r;
        set_quotes(quoting);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        target = sent_items + items;
        while (sent_items < target)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_char(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
            else if (r < 18)
                send_char(pick_char(), 1'($urandom), 1'($urandom), 1'b0);
            else
            begin
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                    send_char(pick_char(), i == 0, i == len - 1, 1'b0);
            end
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the block backs up.
    task automatic test_receiver_hold_off();
        set_quotes(1'b1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_char(pick_char(), i % 6 == 0, i % 6 == 5, 1'b0);
    endtask

    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(2) == 0)
            begin
                out_stall <= 1'b1;
                n = idle_len();
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(5, 1);
            end
            repeat (n - 1) @(posedge clk);
        end
    end

    // Handshakes are sampled at the falling edge ahead of the rising edge that completes them.
    always @(negedge clk)
    begin
        in_take = rst_n && in_valid && !in_stall;
        out_take = rst_n && out_valid && !out_stall;
        got.data = out_byte;
        got.last = last_of_run;
    end

    always @(posedge clk)
    begin
        esc_byte_t want;
        if (out_take)
        begin
            if (expected_bytes.size() == 0)
                note_failure($sformatf("unexpected output byte %02h last_of_run %0b",
                                       got.data, got.last));
            else
            begin
                want = expected_bytes.pop_front();
                if (want.data !== got.data || want.last !== got.last)
                    note_failure($sformatf("output mismatch: expected %02h/%0b, got %02h/%0b",
                                           want.data, want.last, got.data, got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_take || out_take)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        ch = 8'h00;
        first_char = 1'b0;
        last_char = 1'b0;
        empty_string = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_short_escapes();
        test_unicode_escapes();
        test_quoting();
        test_empty_without_quotes();
        test_random_strings(1'b1, 110, 1'b1, 1'b1);
        test_random_strings(1'b0, 90, 1'b1, 1'b1);
        test_receiver_hold_off();
        test_random_strings(1'b1, 70, 1'b0, 1'b0);
        test_random_strings(1'b0, 50, 1'b0, 1'b1);
        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
